>>> hdl/sfpb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfpb_pkg: shared types and constants of the flash-programmer bridge
// Command codes, reply codes, the phase and sequence encodings and the
// functions that expand a queued job into its result words.
// ----------------------------------------------------------------------------
package sfpb_pkg;

    // Command codes of the host protocol.
    localparam logic [7:0] CMD_NOP       = 8'h00;
    localparam logic [7:0] CMD_Q_IFACE   = 8'h01;
    localparam logic [7:0] CMD_Q_CMDMAP  = 8'h02;
    localparam logic [7:0] CMD_Q_PGMNAME = 8'h03;
    localparam logic [7:0] CMD_Q_SERBUF  = 8'h04;
    localparam logic [7:0] CMD_Q_BUSTYPE = 8'h05;
    localparam logic [7:0] CMD_SYNCNOP   = 8'h10;
    localparam logic [7:0] CMD_S_BUSTYPE = 8'h12;
    localparam logic [7:0] CMD_O_SPIOP   = 8'h13;

    // Reply codes and fixed reply values.
    localparam logic [7:0] RSP_ACK      = 8'h06;
    localparam logic [7:0] RSP_NAK      = 8'h15;
    localparam logic [7:0] BUS_SPI      = 8'h08;
    localparam logic [7:0] IFACE_LO     = 8'h01;
    localparam logic [7:0] BUF_SIZE_B   = 8'hFF;
    localparam logic [7:0] SPI_CLOCK_FF = 8'hFF;

    localparam int NAME_BYTES     = 16;
    localparam int NAME_IDX_W     = $clog2(NAME_BYTES);
    localparam int CMD_MAP_BYTES  = 32;
    localparam int CMD_MAP_HEAD   = 4;
    localparam int MAX_RESULTS    = CMD_MAP_BYTES + 1;
    localparam int IDX_W          = $clog2(MAX_RESULTS);
    localparam int LEN_W          = 24;
    localparam int HDR_W          = 3;
    localparam int SFPB_QUEUE_DEPTH = 4;

    localparam logic [7:0] NAME_TABLE [NAME_BYTES] = '{
        8'h75, 8'h61, 8'h72, 8'h74, 8'h2D, 8'h73, 8'h70, 8'h69,
        8'h2D, 8'h62, 8'h72, 8'h69, 8'h64, 8'h67, 8'h65, 8'h00
    };

    localparam logic [7:0] CMD_MAP_TABLE [CMD_MAP_HEAD] = '{
        8'h3F, 8'h00, 8'h0D, 8'h00
    };

    // Header byte positions: three write-length bytes, then three read-length bytes.
    localparam logic [HDR_W-1:0] HDR_WR0 = 3'd0;
    localparam logic [HDR_W-1:0] HDR_WR1 = 3'd1;
    localparam logic [HDR_W-1:0] HDR_WR2 = 3'd2;
    localparam logic [HDR_W-1:0] HDR_RD0 = 3'd3;
    localparam logic [HDR_W-1:0] HDR_RD1 = 3'd4;
    localparam logic [HDR_W-1:0] HDR_RD2 = 3'd5;

    typedef enum logic [1:0] {
        KIND_HOST   = 2'd0,
        KIND_SPI    = 2'd1,
        KIND_SELECT = 2'd2
    } kind_t;

    typedef enum logic [2:0] {
        PH_IDLE      = 3'd0,
        PH_BUS_ARG   = 3'd1,
        PH_HEADER    = 3'd2,
        PH_WRITE     = 3'd3,
        PH_WRITE_RET = 3'd4,
        PH_READ_RET  = 3'd5
    } phase_t;

    // One job per accepted word that produces results.
    typedef enum logic [3:0] {
        SEQ_BYTE      = 4'd0,
        SEQ_IFACE     = 4'd1,
        SEQ_CMDMAP    = 4'd2,
        SEQ_NAME      = 4'd3,
        SEQ_SERBUF    = 4'd4,
        SEQ_BUSTYPE   = 4'd5,
        SEQ_SYNC      = 4'd6,
        SEQ_SPI_BYTE  = 4'd7,
        SEQ_SEL_ON    = 4'd8,
        SEQ_SEL_ON_FF = 4'd9,
        SEQ_SEL_PULSE = 4'd10,
        SEQ_CLOCK_FF  = 4'd11,
        SEQ_SEL_OFF   = 4'd12,
        SEQ_READ_FF   = 4'd13,
        SEQ_READ_OFF  = 4'd14
    } seq_t;

    typedef struct packed {
        seq_t       seq;
        logic [7:0] data;
    } job_t;

    typedef struct packed {
        kind_t      kind;
        logic [7:0] payload;
        logic       select_active;
    } res_t;

    // Index of the final word of a job.
    function automatic logic [IDX_W-1:0] seq_last_idx(seq_t seq);
        logic [IDX_W-1:0] n;
        case (seq)
            SEQ_IFACE:     n = IDX_W'(2);
            SEQ_CMDMAP:    n = IDX_W'(CMD_MAP_BYTES);
            SEQ_NAME:      n = IDX_W'(NAME_BYTES);
            SEQ_SERBUF:    n = IDX_W'(2);
            SEQ_BUSTYPE,
            SEQ_SYNC,
            SEQ_SEL_ON_FF,
            SEQ_SEL_PULSE,
            SEQ_READ_FF,
            SEQ_READ_OFF:  n = IDX_W'(1);
            default:       n = '0;
        endcase
        return n;
    endfunction

    // Word number idx of a job.
    function automatic res_t seq_item(seq_t seq, logic [IDX_W-1:0] idx,
                                      logic [7:0] data);
        res_t             r;
        logic [IDX_W-1:0] rel;
        logic             first;
        rel   = idx - IDX_W'(1);
        first = (idx == '0);
        r.kind          = KIND_HOST;
        r.payload       = 8'h00;
        r.select_active = 1'b0;
        case (seq)
            SEQ_BYTE:
                r.payload = data;
            SEQ_IFACE:
                r.payload = first ? RSP_ACK : ((idx == IDX_W'(1)) ? IFACE_LO : 8'h00);
            SEQ_CMDMAP:
            begin
                if (first)
                    r.payload = RSP_ACK;
                else if (rel < IDX_W'(CMD_MAP_HEAD))
                    r.payload = CMD_MAP_TABLE[rel[$clog2(CMD_MAP_HEAD)-1:0]];
            end
            SEQ_NAME:
                r.payload = first ? RSP_ACK : NAME_TABLE[rel[NAME_IDX_W-1:0]];
            SEQ_SERBUF:
                r.payload = first ? RSP_ACK : BUF_SIZE_B;
            SEQ_BUSTYPE:
                r.payload = first ? RSP_ACK : BUS_SPI;
            SEQ_SYNC:
                r.payload = first ? RSP_NAK : RSP_ACK;
            SEQ_SPI_BYTE:
            begin
                r.kind          = KIND_SPI;
                r.payload       = data;
                r.select_active = 1'b1;
            end
            SEQ_SEL_ON:
            begin
                r.kind          = KIND_SELECT;
                r.select_active = 1'b1;
            end
            SEQ_SEL_ON_FF:
            begin
                r.kind          = first ? KIND_SELECT : KIND_SPI;
                r.payload       = first ? 8'h00 : SPI_CLOCK_FF;
                r.select_active = 1'b1;
            end
            SEQ_SEL_PULSE:
            begin
                r.kind          = KIND_SELECT;
                r.select_active = first;
            end
            SEQ_CLOCK_FF:
            begin
                r.kind          = KIND_SPI;
                r.payload       = SPI_CLOCK_FF;
                r.select_active = 1'b1;
            end
            SEQ_SEL_OFF:
                r.kind = KIND_SELECT;
            SEQ_READ_FF:
            begin
                r.kind          = first ? KIND_HOST : KIND_SPI;
                r.payload       = first ? data : SPI_CLOCK_FF;
                r.select_active = 1'b1;
            end
            SEQ_READ_OFF:
            begin
                r.kind          = first ? KIND_HOST : KIND_SELECT;
                r.payload       = first ? data : 8'h00;
                r.select_active = first;
            end
            default:
                r.payload = 8'h00;
        endcase
        return r;
    endfunction

endpackage

>>> hdl/sfpb_channels.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfpb channels: valid/ready interfaces of the bridge
// The input channel carries received words, the output channel result words.
// ----------------------------------------------------------------------------
interface sfpb_item_if;
    logic       valid;
    logic       ready;
    logic       op;
    logic [7:0] data;

    modport source (output valid, output op, output data, input ready);
    modport sink   (input valid, input op, input data, output ready);
endinterface

interface sfpb_result_if;
    logic       valid;
    logic       ready;
    logic [1:0] kind;
    logic [7:0] payload;
    logic       select_active;
    logic       last;

    modport source (output valid, output kind, output payload,
                    output select_active, output last, input ready);
    modport sink   (input valid, input kind, input payload,
                    input select_active, input last, output ready);
endinterface

>>> hdl/sfpb_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfpb_front: protocol tracker
// Follows the command phase and SPI transfer lengths for every accepted
// word and turns each word that has results into one job for the queue.
// ----------------------------------------------------------------------------
module sfpb_front (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           fire,
    input  logic           op,
    input  logic [7:0]     data,
    output logic           push,
    output sfpb_pkg::job_t job
);
    import sfpb_pkg::*;

    phase_t             phase_reg,     phase_next;
    logic [HDR_W-1:0]   hdr_idx_reg,   hdr_idx_next;
    logic [LEN_W-1:0]   write_left_reg, write_left_next;
    logic [LEN_W-1:0]   read_left_reg,  read_left_next;

    logic [LEN_W-1:0]   write_dec;
    logic [LEN_W-1:0]   read_dec;
    logic [LEN_W-1:0]   read_full;

    assign write_dec = write_left_reg - LEN_W'(1);
    assign read_dec  = read_left_reg - LEN_W'(1);
    // Read length once its top byte arrives.
    assign read_full = {data, read_left_reg[15:0]};

    // Next state.
    always_comb
    begin
        phase_next      = phase_reg;
        hdr_idx_next    = hdr_idx_reg;
        write_left_next = write_left_reg;
        read_left_next  = read_left_reg;
        if (fire)
        begin
            if (!op)
            begin
                unique case (phase_reg)
                    PH_IDLE:
                    begin
                        if (data == CMD_S_BUSTYPE)
                            phase_next = PH_BUS_ARG;
                        else if (data == CMD_O_SPIOP)
                        begin
                            phase_next      = PH_HEADER;
                            hdr_idx_next    = '0;
                            write_left_next = '0;
                            read_left_next  = '0;
                        end
                    end
                    PH_BUS_ARG:
                        phase_next = PH_IDLE;
                    PH_HEADER:
                    begin
                        case (hdr_idx_reg)
                            HDR_WR0: write_left_next[7:0]   = data;
                            HDR_WR1: write_left_next[15:8]  = data;
                            HDR_WR2: write_left_next[23:16] = data;
                            HDR_RD0: read_left_next[7:0]    = data;
                            HDR_RD1: read_left_next[15:8]   = data;
                            HDR_RD2: read_left_next[23:16]  = data;
                            default: read_left_next         = read_left_reg;
                        endcase
                        if (hdr_idx_reg == HDR_RD2)
                        begin
                            hdr_idx_next = '0;
                            if (write_left_reg != '0)
                                phase_next = PH_WRITE;
                            else if (read_full != '0)
                                phase_next = PH_READ_RET;
                            else
                                phase_next = PH_IDLE;
                        end
                        else
                            hdr_idx_next = hdr_idx_reg + HDR_W'(1);
                    end
                    PH_WRITE:
                    begin
                        write_left_next = write_dec;
                        phase_next      = PH_WRITE_RET;
                    end
                    default:
                        phase_next = phase_reg;
                endcase
            end
            else if (phase_reg == PH_WRITE_RET)
            begin
                if (write_left_reg != '0)
                    phase_next = PH_WRITE;
                else if (read_left_reg != '0)
                    phase_next = PH_READ_RET;
                else
                    phase_next = PH_IDLE;
            end
            else if (phase_reg == PH_READ_RET)
            begin
                read_left_next = read_dec;
                phase_next     = (read_dec != '0) ? PH_READ_RET : PH_IDLE;
            end
        end
    end

    // Job for the back part.
    always_comb
    begin
        push     = 1'b0;
        job.seq  = SEQ_BYTE;
        job.data = data;
        if (fire)
        begin
            if (!op)
            begin
                unique case (phase_reg)
                    PH_IDLE:
                    begin
                        push = 1'b1;
                        case (data)
                            CMD_NOP:       job.data = RSP_ACK;
                            CMD_Q_IFACE:   job.seq  = SEQ_IFACE;
                            CMD_Q_CMDMAP:  job.seq  = SEQ_CMDMAP;
                            CMD_Q_PGMNAME: job.seq  = SEQ_NAME;
                            CMD_Q_SERBUF:  job.seq  = SEQ_SERBUF;
                            CMD_Q_BUSTYPE: job.seq  = SEQ_BUSTYPE;
                            CMD_SYNCNOP:   job.seq  = SEQ_SYNC;
                            CMD_S_BUSTYPE: push     = 1'b0;
                            CMD_O_SPIOP:   job.data = RSP_ACK;
                            default:       job.data = RSP_NAK;
                        endcase
                    end
                    PH_BUS_ARG:
                    begin
                        push     = 1'b1;
                        job.data = ((data | BUS_SPI) == BUS_SPI) ? RSP_ACK : RSP_NAK;
                    end
                    PH_HEADER:
                    begin
                        if (hdr_idx_reg == HDR_RD2)
                        begin
                            push = 1'b1;
                            if (write_left_reg != '0)
                                job.seq = SEQ_SEL_ON;
                            else if (read_full != '0)
                                job.seq = SEQ_SEL_ON_FF;
                            else
                                job.seq = SEQ_SEL_PULSE;
                        end
                    end
                    PH_WRITE:
                    begin
                        push    = 1'b1;
                        job.seq = SEQ_SPI_BYTE;
                    end
                    default:
                        push = 1'b0;
                endcase
            end
            else if (phase_reg == PH_WRITE_RET)
            begin
                push = (write_left_reg == '0);
                job.seq = (read_left_reg != '0) ? SEQ_CLOCK_FF : SEQ_SEL_OFF;
            end
            else if (phase_reg == PH_READ_RET)
            begin
                push    = 1'b1;
                job.seq = (read_dec != '0) ? SEQ_READ_FF : SEQ_READ_OFF;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_IDLE;
            hdr_idx_reg    <= '0;
            write_left_reg <= '0;
            read_left_reg  <= '0;
        end
        else
        begin
            phase_reg      <= phase_next;
            hdr_idx_reg    <= hdr_idx_next;
            write_left_reg <= write_left_next;
            read_left_reg  <= read_left_next;
        end
    end

endmodule

>>> hdl/sfpb_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfpb_queue: job queue between front and back
// A small register FIFO; the head entry is presented without delay.
// ----------------------------------------------------------------------------
module sfpb_queue #(
    parameter int DEPTH = sfpb_pkg::SFPB_QUEUE_DEPTH
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  sfpb_pkg::job_t job_in,
    output logic           full,
    input  logic           pop,
    output logic           valid,
    output sfpb_pkg::job_t job_out
);
    import sfpb_pkg::*;

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    job_t             entries_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg,  count_next;
    logic             do_push;
    logic             do_pop;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign valid   = (count_reg != '0);
    assign job_out = entries_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        if (do_push && !do_pop)
            count_next = count_reg + CNT_W'(1);
        else if (do_pop && !do_push)
            count_next = count_reg - CNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            entries_reg[wr_ptr_reg] <= job_in;
    end

endmodule

>>> hdl/sfpb_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfpb_back: result sequencer
// Steps through the words of the job at the head of the queue into a
// registered output stage, one word per cycle while it is empty or draining.
// ----------------------------------------------------------------------------
module sfpb_back (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           job_valid,
    input  sfpb_pkg::job_t job,
    output logic           pop,
    output logic           out_valid,
    output sfpb_pkg::res_t out_res,
    output logic           out_last,
    input  logic           out_ready
);
    import sfpb_pkg::*;

    logic [IDX_W-1:0] idx_reg,   idx_next;
    logic             valid_reg, valid_next;
    res_t             res_reg;
    logic             last_reg;
    logic             issue;
    logic             at_last;

    // A word moves into the output stage when it is empty or being drained.
    assign issue   = job_valid && (!valid_reg || out_ready);
    assign at_last = (idx_reg == seq_last_idx(job.seq));
    assign pop     = issue && at_last;

    always_comb
    begin
        idx_next   = idx_reg;
        valid_next = valid_reg;
        if (issue)
        begin
            idx_next   = at_last ? '0 : idx_reg + IDX_W'(1);
            valid_next = 1'b1;
        end
        else if (out_ready)
            valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg   <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg   <= idx_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (issue)
        begin
            res_reg  <= seq_item(job.seq, idx_reg, job.data);
            last_reg <= at_last;
        end
    end

    assign out_valid = valid_reg;
    assign out_res   = res_reg;
    assign out_last  = last_reg;

endmodule

>>> hdl/serial_flash_programmer_bridge_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// serial_flash_programmer_bridge_top: serial flash-programmer protocol bridge
// Parses host commands and SPI return bytes and produces host replies,
// SPI transmit bytes and chip-select changes.
// ----------------------------------------------------------------------------
// Usage. The item channel takes one word per handshake: op low for a byte
// from the host, op high for a byte returned by an SPI exchange. The result
// channel gives one word per handshake: kind says whether the byte goes to
// the host, to the SPI shifter, or whether the word is only a chip-select
// change; select_active is the select level after that word, and last marks
// the final word caused by one input word.
// The first result word of an input word is queued when the input word is
// accepted and then moves into the sequencer's registered output stage.
// Throughput: one input word per cycle while the job queue (QUEUE_DEPTH
// entries) has room, and one result word per cycle out of the result
// sequencer while the receiver takes them. A query that answers with many
// words, such as the 33-word command map, holds the sequencer until its
// last word is out; input words are still accepted until the queue fills.
// Reset clears the protocol phase, transfer lengths, queue and output stage;
// select is deasserted. When the receiver stalls, the current result word
// holds in the output register and the queue absorbs further jobs before the
// item channel drops ready.
// ----------------------------------------------------------------------------
module serial_flash_programmer_bridge_top #(
    parameter int QUEUE_DEPTH = sfpb_pkg::SFPB_QUEUE_DEPTH
) (
    input  logic          clk,
    input  logic          rst_n,
    sfpb_item_if.sink     item,
    sfpb_result_if.source result
);
    import sfpb_pkg::*;

    // Front to queue.
    logic fire;
    logic q_push;
    job_t q_job_in;
    logic q_full;

    // Queue to back.
    logic q_valid;
    logic q_pop;
    job_t q_job_out;

    // Back output stage.
    logic out_valid;
    res_t out_res;
    logic out_last;

    // The front never stalls on its own: it only waits for queue room.
    assign item.ready = !q_full;
    assign fire       = item.valid && !q_full;

    sfpb_front u_front (
        .clk   (clk),
        .rst_n (rst_n),
        .fire  (fire),
        .op    (item.op),
        .data  (item.data),
        .push  (q_push),
        .job   (q_job_in)
    );

    sfpb_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (q_push),
        .job_in  (q_job_in),
        .full    (q_full),
        .pop     (q_pop),
        .valid   (q_valid),
        .job_out (q_job_out)
    );

    sfpb_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_valid (q_valid),
        .job       (q_job_out),
        .pop       (q_pop),
        .out_valid (out_valid),
        .out_res   (out_res),
        .out_last  (out_last),
        .out_ready (result.ready)
    );

    assign result.valid         = out_valid;
    assign result.kind          = out_res.kind;
    assign result.payload       = out_res.payload;
    assign result.select_active = out_res.select_active;
    assign result.last          = out_last;

    // The front only produces a job when it accepted a word.
    a_push_needs_fire : assert property (@(posedge clk) disable iff (!rst_n)
        q_push |-> fire)
        else $error("job pushed without an accepted word");

    // Retiring a job leaves its final word in the output stage.
    a_pop_marks_last : assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |=> (result.valid && result.last))
        else $error("job retired without a last word");

    // Select-only words carry a zero byte.
    a_select_zero : assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && result.kind == KIND_SELECT) |-> (result.payload == 8'h00))
        else $error("select word with non-zero payload");

endmodule

>>> test/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench of the serial flash-programmer bridge
// A short table of words exercises every command, the bus-type check, the
// ignored words and both kinds of SPI transfer. A random stream of protocol
// sequences follows. Every result word is compared with the bridge's replies
// as worked out inside the bench, with random gaps on both channels.
// ----------------------------------------------------------------------------
module tb_top;

    import sfpb_pkg::*;

    // Source of an input word.
    localparam logic OP_HOST = 1'b0;
    localparam logic OP_SPI  = 1'b1;

    localparam int    RANDOM_WORDS = 280;
    localparam int    SETTLE_CYCLES = 20;
    localparam int    STALL_LIMIT   = 3000;
    localparam string BRIDGE_NAME   = "uart-spi-bridge";
    localparam logic [7:0] MAP_HEAD [4] = '{8'h3F, 8'h00, 8'h0D, 8'h00};

    // One result word as the bridge should give it.
    typedef struct packed {
        kind_t      kind;
        logic [7:0] payload;
        logic       sel;
        logic       last;
    } bridge_word_t;

    // One row of the directed table. Where typed is set, the row causes one
    // word only, and that word is written out here in full.
    typedef struct {
        logic       op;
        logic [7:0] data;
        bit         typed;
        kind_t      kind;
        logic [7:0] payload;
        logic       sel;
    } stim_row_t;

    localparam int PLAN_ROWS = 31;

    stim_row_t plan [PLAN_ROWS] = '{
        // Every query once; NOP and an unknown code are read off directly.
        '{OP_HOST, CMD_NOP,       1'b1, KIND_HOST, RSP_ACK, 1'b0},
        '{OP_HOST, CMD_Q_IFACE,   1'b0, KIND_HOST, 8'h00,   1'b0},
        '{OP_HOST, CMD_Q_CMDMAP,  1'b0, KIND_HOST, 8'h00,   1'b0},
        '{OP_HOST, CMD_Q_PGMNAME, 1'b0, KIND_HOST, 8'h00,   1'b0},
        '{OP_HOST, CMD_Q_SERBUF,  1'b0, KIND_HOST, 8'h00,   1'b0},
        '{OP_HOST, CMD_Q_BUSTYPE, 1'b0, KIND_HOST, 8'h00,   1'b0},
        '{OP_HOST, CMD_SYNCNOP,   1'b0, KIND_HOST, 8'h00,   1'b0},
        '{OP_HOST, 8'hFF,         1'b1, KIND_HOST, RSP_NAK, 1'b0},
        // An SPI word with no transfer open is dropped.
        '{OP_SPI,  8'hAA,         1'b0, KIND_HOST, 8'h00,   1'b0},
        // Bus type: SPI accepted, a value with other bits set refused.
        '{OP_HOST, CMD_S_BUSTYPE, 1'b0, KIND_HOST, 8'h00,   1'b0},
        '{OP_HOST, BUS_SPI,       1'b1, KIND_HOST, RSP_ACK, 1'b0},
        '{OP_HOST, CMD_S_BUSTYPE, 1'b0, KIND_HOST, 8'h00,   1'b0},
        '{OP_HOST, 8'hF7,         1'b1, KIND_HOST, RSP_NAK, 1'b0},
        // Transfer with both lengths zero: select pulses within one word.
        '{OP_HOST, CMD_O_SPIOP,   1'b1, KIND_HOST, RSP_ACK, 1'b0},
        '{OP_HOST, 8'h00,         1'b0, KIND_HOST, 8'h00,   1'b0},
        '{OP_HOST, 8'h00,         1'b0, KIND_HOST, 8'h00,   1'b0},
        '{OP_HOST, 8'h00,         1'b0, KIND_HOST, 8'h00,   1'b0},
        '{OP_HOST, 8'h00,         1'b0, KIND_HOST, 8'h00,   1'b0},
        '{OP_HOST, 8'h00,         1'b0, KIND_HOST, 8'h00,   1'b0},
        '{OP_HOST, 8'h00,         1'b0, KIND_HOST, 8'h00,   1'b0},
        // Transfer of one write byte and one read byte.
        '{OP_HOST, CMD_O_SPIOP,   1'b1, KIND_HOST, RSP_ACK, 1'b0},
        '{OP_HOST, 8'h01,         1'b0, KIND_HOST, 8'h00,   1'b0},
        '{OP_HOST, 8'h00,         1'b0, KIND_HOST, 8'h00,   1'b0},
        '{OP_HOST, 8'h00,         1'b0, KIND_HOST, 8'h00,   1'b0},
        '{OP_HOST, 8'h01,         1'b0, KIND_HOST, 8'h00,   1'b0},
        '{OP_HOST, 8'h00,         1'b0, KIND_HOST, 8'h00,   1'b0},
        '{OP_HOST, 8'h00,         1'b0, KIND_HOST, 8'h00,   1'b0},
        '{OP_HOST, 8'hA5,         1'b1, KIND_SPI,  8'hA5,   1'b1},
        // A host word while an SPI return is awaited is dropped.
        '{OP_HOST, 8'h5A,         1'b0, KIND_HOST, 8'h00,   1'b0},
        // The write return is discarded, then the read clock and its return.
        '{OP_SPI,  8'h00,         1'b0, KIND_HOST, 8'h00,   1'b0},
        '{OP_SPI,  8'hC3,         1'b0, KIND_HOST, 8'h00,   1'b0}
    };

    logic clk;
    logic rst_n;

    sfpb_item_if   item_ch ();
    sfpb_result_if result_ch ();

    serial_flash_programmer_bridge_top uut (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item_ch),
        .result (result_ch)
    );

    // The bench's own copy of the bridge's protocol state.
    phase_t      ph;
    logic [2:0]  hdr_cnt;
    logic [23:0] wr_left;
    logic [23:0] rd_left;
    logic        sel_lvl;

    // Words caused by the latest accepted input word, and all words still due.
    bridge_word_t step_words [$];
    bridge_word_t out_words_due [$];

    int errors;
    int idle_cycles;
    int sender_calm;
    int rx_hold;
    int rx_calm;

    // Clock of 10 ns period.
    initial clk = 1'b0;
    always #5 clk = ~clk;

    // Length of a pause on either channel: mostly none or short, now and then
    // a long one.
    function automatic int idle_span();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 85)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 12);
        else
            return $urandom_range(25, 60);
    endfunction

    // Appends one word, tagged with the select level as it now stands.
    function automatic void emit(kind_t k, logic [7:0] p);
        bridge_word_t w;
        w.kind    = k;
        w.payload = p;
        w.sel     = sel_lvl;
        w.last    = 1'b0;
        step_words.push_back(w);
    endfunction

    // Either clocks out the next read byte or, with nothing left to read,
    // drops select and closes the transfer.
    function automatic void next_read_clock();
        if (rd_left != 24'd0)
        begin
            emit(KIND_SPI, 8'hFF);
            ph = PH_READ_RET;
        end
        else
        begin
            sel_lvl = 1'b0;
            emit(KIND_SELECT, 8'h00);
            ph = PH_IDLE;
        end
    endfunction

    // Works out the bridge's reply to one accepted word and moves the
    // protocol state on. The words land in step_words, the final one marked.
    function automatic void bridge_respond(logic op, logic [7:0] d);
        step_words.delete();
        if (op == OP_HOST)
        begin
            case (ph)
                PH_IDLE:
                begin
                    case (d)
                        CMD_NOP:
                            emit(KIND_HOST, RSP_ACK);
                        CMD_Q_IFACE:
                        begin
                            emit(KIND_HOST, RSP_ACK);
                            emit(KIND_HOST, 8'h01);
                            emit(KIND_HOST, 8'h00);
                        end
                        CMD_Q_CMDMAP:
                        begin
                            emit(KIND_HOST, RSP_ACK);
                            for (int i = 0; i < 32; i++)
                                emit(KIND_HOST, (i < 4) ? MAP_HEAD[i] : 8'h00);
                        end
                        CMD_Q_PGMNAME:
                        begin
                            emit(KIND_HOST, RSP_ACK);
                            for (int i = 0; i < 16; i++)
                                emit(KIND_HOST, (i < BRIDGE_NAME.len()) ?
                                     8'(BRIDGE_NAME[i]) : 8'h00);
                        end
                        CMD_Q_SERBUF:
                        begin
                            emit(KIND_HOST, RSP_ACK);
                            emit(KIND_HOST, 8'hFF);
                            emit(KIND_HOST, 8'hFF);
                        end
                        CMD_Q_BUSTYPE:
                        begin
                            emit(KIND_HOST, RSP_ACK);
                            emit(KIND_HOST, BUS_SPI);
                        end
                        CMD_SYNCNOP:
                        begin
                            emit(KIND_HOST, RSP_NAK);
                            emit(KIND_HOST, RSP_ACK);
                        end
                        CMD_S_BUSTYPE:
                            ph = PH_BUS_ARG;
                        CMD_O_SPIOP:
                        begin
                            emit(KIND_HOST, RSP_ACK);
                            hdr_cnt = 3'd0;
                            wr_left = 24'd0;
                            rd_left = 24'd0;
                            ph      = PH_HEADER;
                        end
                        default:
                            emit(KIND_HOST, RSP_NAK);
                    endcase
                end
                PH_BUS_ARG:
                begin
                    emit(KIND_HOST, ((d | BUS_SPI) == BUS_SPI) ? RSP_ACK : RSP_NAK);
                    ph = PH_IDLE;
                end
                PH_HEADER:
                begin
                    // Both lengths arrive least significant byte first.
                    if (hdr_cnt < 3'd3)
                        wr_left = wr_left | (24'(d) << (8 * hdr_cnt));
                    else if (hdr_cnt < 3'd6)
                        rd_left = rd_left | (24'(d) << (8 * (hdr_cnt - 3'd3)));
                    hdr_cnt = hdr_cnt + 3'd1;
                    if (hdr_cnt >= 3'd6)
                    begin
                        hdr_cnt = 3'd0;
                        sel_lvl = 1'b1;
                        emit(KIND_SELECT, 8'h00);
                        if (wr_left != 24'd0)
                            ph = PH_WRITE;
                        else
                            next_read_clock();
                    end
                end
                PH_WRITE:
                begin
                    emit(KIND_SPI, d);
                    wr_left = wr_left - 24'd1;
                    ph      = PH_WRITE_RET;
                end
                default:
                    ;
            endcase
        end
        else if (ph == PH_WRITE_RET)
        begin
            if (wr_left != 24'd0)
                ph = PH_WRITE;
            else
                next_read_clock();
        end
        else if (ph == PH_READ_RET)
        begin
            emit(KIND_HOST, d);
            rd_left = rd_left - 24'd1;
            next_read_clock();
        end
        if (step_words.size() != 0)
            step_words[step_words.size() - 1].last = 1'b1;
    endfunction

    // Offers one word after a random gap, waits for it to be taken and books
    // the bridge's reply if use_model is set. Entered and left at a falling
    // edge; valid stays high on return so a following word needs no gap.
    task automatic send_word(logic op, logic [7:0] d, bit use_model);
        int gap;
        if (sender_calm > 0)
        begin
            sender_calm--;
            gap = 0;
        end
        else
        begin
            gap = idle_span();
            if ($urandom_range(0, 39) == 0)
                sender_calm = $urandom_range(20, 50);
        end
        if (gap > 0)
        begin
            item_ch.valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        item_ch.valid = 1'b1;
        item_ch.op    = op;
        item_ch.data  = d;
        do
            @(posedge clk);
        while (!item_ch.ready);
        bridge_respond(op, d);
        if (use_model)
            foreach (step_words[k])
                out_words_due.push_back(step_words[k]);
        @(negedge clk);
    endtask

    // Holds the item channel back until every booked word has come out.
    task automatic drain_results();
        if (out_words_due.size() != 0)
        begin
            item_ch.valid = 1'b0;
            while (out_words_due.size() != 0)
                @(negedge clk);
        end
    endtask

    // Result channel: ready drops for random stretches, with long spells of
    // no stalling at all now and then.
    always @(negedge clk)
    begin
        if (rx_hold > 0)
        begin
            result_ch.ready = 1'b0;
            rx_hold--;
        end
        else
        begin
            result_ch.ready = 1'b1;
            if (rx_calm > 0)
                rx_calm--;
            else if ($urandom_range(0, 59) == 0)
                rx_calm = $urandom_range(40, 120);
            else
                rx_hold = idle_span();
        end
    end

    // Every word taken from the bridge is compared with the oldest word due.
    always @(posedge clk)
    begin
        bridge_word_t w;
        if (rst_n && result_ch.valid && result_ch.ready)
        begin
            if (out_words_due.size() == 0)
            begin
                $display("%0t: unexpected word: kind %0d payload %02h select %0d last %0d",
                         $time, result_ch.kind, result_ch.payload,
                         result_ch.select_active, result_ch.last);
                errors++;
            end
            else
            begin
                w = out_words_due.pop_front();
                if (result_ch.kind !== w.kind || result_ch.payload !== w.payload ||
                    result_ch.select_active !== w.sel || result_ch.last !== w.last)
                begin
                    $display({"%0t: mismatch: expected kind %0d payload %02h ",
                              "select %0d last %0d, got kind %0d payload %02h ",
                              "select %0d last %0d"},
                             $time, w.kind, w.payload, w.sel, w.last,
                             result_ch.kind, result_ch.payload,
                             result_ch.select_active, result_ch.last);
                    errors++;
                end
            end
        end
    end

    // Watchdog: the run is given up once neither channel has moved a word for
    // too long. Every pause the bench makes on purpose is far shorter.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= STALL_LIMIT)
            begin
                $display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
                $display("serial_flash_programmer_bridge_top test failed");
                $finish;
            end
        end
    end

    initial
    begin
        int         sent;
        int         r;
        bit         noise;
        bit         paused;
        logic       op;
        logic [7:0] d;

        sent   = 0;
        paused = 1'b0;

        errors      = 0;
        idle_cycles = 0;
        sender_calm = 0;
        rx_hold     = 0;
        rx_calm     = 0;

        // The bench's view of the bridge starts from the reset state.
        ph      = PH_IDLE;
        hdr_cnt = 3'd0;
        wr_left = 24'd0;
        rd_left = 24'd0;
        sel_lvl = 1'b0;

        item_ch.valid   = 1'b0;
        item_ch.op      = OP_HOST;
        item_ch.data    = 8'h00;
        result_ch.ready = 1'b0;

        rst_n = 1'b0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed part. Rows with a word typed in are checked against that
        // word; the state is still moved on so that later rows line up.
        for (int i = 0; i < PLAN_ROWS; i++)
        begin
            send_word(plan[i].op, plan[i].data, !plan[i].typed);
            if (plan[i].typed)
                out_words_due.push_back('{kind: plan[i].kind, payload: plan[i].payload,
                                          sel: plan[i].sel, last: 1'b1});
        end

        // The sender waits here until the bridge has said everything it owes.
        drain_results();

        // Random part. The next word is chosen from where the protocol stands,
        // so most of the traffic is well-formed commands and transfers with
        // random contents; the rest is bad arguments, unknown codes and words
        // that the bridge should drop. Dropped words are not counted.
        while (sent < RANDOM_WORDS || ph != PH_IDLE)
        begin
            noise = 1'b0;
            op    = OP_HOST;
            d     = 8'($urandom_range(0, 255));
            r     = $urandom_range(0, 99);
            case (ph)
                PH_IDLE:
                begin
                    if (r < 8)
                    begin
                        op    = OP_SPI;
                        noise = 1'b1;
                    end
                    else
                    begin
                        r = $urandom_range(0, 99);
                        if (r < 10)
                            d = CMD_NOP;
                        else if (r < 16)
                            d = CMD_Q_IFACE;
                        else if (r < 20)
                            d = CMD_Q_CMDMAP;
                        else if (r < 25)
                            d = CMD_Q_PGMNAME;
                        else if (r < 31)
                            d = CMD_Q_SERBUF;
                        else if (r < 37)
                            d = CMD_Q_BUSTYPE;
                        else if (r < 45)
                            d = CMD_SYNCNOP;
                        else if (r < 58)
                            d = CMD_S_BUSTYPE;
                        else if (r < 85)
                            d = CMD_O_SPIOP;
                        // Otherwise a random code, mostly an unknown one.
                    end
                end
                PH_BUS_ARG:
                begin
                    if (r < 35)
                        d = 8'h00;
                    else if (r < 70)
                        d = BUS_SPI;
                end
                PH_HEADER:
                begin
                    // Lengths are kept short so that each transfer ends soon;
                    // only the low length bytes carry a value.
                    if (r < 5)
                    begin
                        op    = OP_SPI;
                        noise = 1'b1;
                    end
                    else if (hdr_cnt == HDR_WR0 || hdr_cnt == HDR_RD0)
                        d = (r < 10) ? 8'($urandom_range(7, 24)) : 8'($urandom_range(0, 6));
                    else
                        d = 8'h00;
                end
                PH_WRITE:
                begin
                    if (r < 6)
                    begin
                        op    = OP_SPI;
                        noise = 1'b1;
                    end
                end
                default:
                begin
                    // An SPI return is awaited; a host word now is dropped.
                    if (r < 6)
                        noise = 1'b1;
                    else
                        op = OP_SPI;
                end
            endcase
            send_word(op, d, 1'b1);
            if (!noise)
                sent++;
            if (!paused && sent >= RANDOM_WORDS / 2)
            begin
                paused = 1'b1;
                drain_results();
            end
        end

        // All stimulus is in: wait for the last words, then a little longer
        // so that any stray word from the bridge is caught.
        item_ch.valid = 1'b0;
        drain_results();
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (errors == 0)
            $display("serial_flash_programmer_bridge_top test passed");
        else
            $display("serial_flash_programmer_bridge_top test failed");
        $finish;
    end

endmodule
